[src/bcc_pkg.sv]
package bcc_pkg;

   localparam int unsigned TIMER_W   = 16;
   localparam int unsigned TICK_W    = 8;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_PRESS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DOUBLE_WINDOW = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TICK          = 2'd2;

   localparam logic [TIMER_W-1:0] LONG_PRESS_RESET    = 16'd800;
   localparam logic [TIMER_W-1:0] DOUBLE_WINDOW_RESET = 16'd300;
   localparam logic [TICK_W-1:0]  TICK_RESET          = 8'd10;

   typedef enum logic [1:0] {
      PHASE_IDLE     = 2'd0,
      PHASE_DEBOUNCE = 2'd1,
      PHASE_PRESSED  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   typedef struct packed {
      logic [TIMER_W-1:0] long_press_ms;
      logic [TIMER_W-1:0] double_window_ms;
      logic [TICK_W-1:0]  tick_ms;
   } cfg_type;

   typedef struct packed {
      phase_type          phase;
      logic [TIMER_W-1:0] hold_ms;
      logic               window_open;
      logic [TIMER_W-1:0] window_ms;
      event_type          last_event;
   } state_type;

endpackage

[src/bcc_step.sv]
module bcc_step (
   input  bcc_pkg::cfg_type   cfg,
   input  bcc_pkg::state_type cur,
   input  logic               released,
   output bcc_pkg::state_type nxt,
   output logic               fired
);

   bcc_pkg::phase_type phase_next;

   // next phase
   always_comb begin
      unique case (cur.phase)
         bcc_pkg::PHASE_DEBOUNCE: begin
            phase_next = released ? bcc_pkg::PHASE_IDLE : bcc_pkg::PHASE_PRESSED;
         end
         bcc_pkg::PHASE_PRESSED: begin
            phase_next = released ? bcc_pkg::PHASE_IDLE : bcc_pkg::PHASE_PRESSED;
         end
         default: begin
            phase_next = released ? bcc_pkg::PHASE_IDLE : bcc_pkg::PHASE_DEBOUNCE;
         end
      endcase
   end

   // timers, window and event
   always_comb begin
      logic [bcc_pkg::TIMER_W:0]   hold_sum;
      logic [bcc_pkg::TIMER_W:0]   win_sum;
      logic [bcc_pkg::TIMER_W-1:0] win_mid;
      logic [bcc_pkg::TIMER_W-1:0] win_sat;
      logic                        open_mid;

      hold_sum = {1'b0, cur.hold_ms} + {{(bcc_pkg::TIMER_W+1-bcc_pkg::TICK_W){1'b0}}, cfg.tick_ms};
      nxt          = cur;
      nxt.phase    = phase_next;
      fired        = 1'b0;
      open_mid     = cur.window_open;
      win_mid      = cur.window_ms;

      unique case (cur.phase)
         bcc_pkg::PHASE_DEBOUNCE: begin
         end
         bcc_pkg::PHASE_PRESSED: begin
            if (released) begin
               if (cur.hold_ms < cfg.long_press_ms) begin
                  if (!cur.window_open) begin
                     open_mid = 1'b1;
                     win_mid  = '0;
                  end else begin
                     nxt.last_event = bcc_pkg::EV_DOUBLE;
                     open_mid       = 1'b0;
                     fired          = 1'b1;
                  end
               end else begin
                  nxt.last_event = bcc_pkg::EV_LONG;
                  fired          = 1'b1;
               end
            end else begin
               nxt.hold_ms = hold_sum[bcc_pkg::TIMER_W] ? bcc_pkg::TIMER_MAX
                                                        : hold_sum[bcc_pkg::TIMER_W-1:0];
            end
         end
         default: begin
            if (!released) begin
               nxt.hold_ms = '0;
            end
         end
      endcase

      // window advances in the same tick, including the one that opened it
      win_sum = {1'b0, win_mid} + {{(bcc_pkg::TIMER_W+1-bcc_pkg::TICK_W){1'b0}}, cfg.tick_ms};
      win_sat = win_sum[bcc_pkg::TIMER_W] ? bcc_pkg::TIMER_MAX : win_sum[bcc_pkg::TIMER_W-1:0];
      nxt.window_open = open_mid;
      nxt.window_ms   = win_mid;
      if (open_mid) begin
         nxt.window_ms = win_sat;
         if (win_sat > cfg.double_window_ms) begin
            nxt.last_event  = bcc_pkg::EV_SINGLE;
            nxt.window_open = 1'b0;
            fired           = 1'b1;
         end
      end
   end

endmodule

[src/button_click_classifier.sv]
// A tick transaction's result is registered at acceptance and then shown on rsp_tdata.
// Throughput: one tick per cycle; the classifier state updates at acceptance and
// the result register frees as it is taken, so req_tready only drops on a stalled rsp.
// Reset (synchronous, active high): registers back to 800/300/10 ms, phase idle,
// timers zero, window closed, last event none, no result pending.
module button_click_classifier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [0] key_level
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // [1:0] event_code, [2] event_fired
   input  logic                              csr_we,
   input  logic [bcc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   bcc_pkg::cfg_type   cfg_ff;
   bcc_pkg::state_type state_ff;
   bcc_pkg::state_type state_in;
   logic               fired_in;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_code_ff;
   logic               rsp_fired_ff;
   logic               req_accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   bcc_step u_step (
      .cfg      (cfg_ff),
      .cur      (state_ff),
      .released (req_tdata[0]),
      .nxt      (state_in),
      .fired    (fired_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms    <= bcc_pkg::LONG_PRESS_RESET;
         cfg_ff.double_window_ms <= bcc_pkg::DOUBLE_WINDOW_RESET;
         cfg_ff.tick_ms          <= bcc_pkg::TICK_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            bcc_pkg::CSR_LONG_PRESS:    cfg_ff.long_press_ms    <= csr_wdata;
            bcc_pkg::CSR_DOUBLE_WINDOW: cfg_ff.double_window_ms <= csr_wdata;
            bcc_pkg::CSR_TICK:          cfg_ff.tick_ms <= csr_wdata[bcc_pkg::TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= bcc_pkg::PHASE_IDLE;
         state_ff.hold_ms     <= '0;
         state_ff.window_open <= 1'b0;
         state_ff.window_ms   <= '0;
         state_ff.last_event  <= bcc_pkg::EV_NONE;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_code_ff  <= state_in.last_event;
         rsp_fired_ff <= fired_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_fired_ff, rsp_code_ff};

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   a_code_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_code_ff == state_ff.last_event))
      else $error("result code differs from latched event");

   a_debounce_hold_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == bcc_pkg::PHASE_DEBOUNCE) |-> (state_ff.hold_ms == '0))
      else $error("hold timer not cleared on press");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(rsp_code_ff) && $stable(rsp_fired_ff)))
      else $error("pending result overwritten");

endmodule
